// ----- hdl/upgrade_header_list_parser_defines.svh -----
// Assertion macros for the upgrade header list parser.
`ifndef UPGRADE_HEADER_LIST_PARSER_DEFINES_SVH
`define UPGRADE_HEADER_LIST_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define UHLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("uhlp assertion failed");
// Next-cycle implication, checked out of reset.
`define UHLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("uhlp assertion failed");
`else
`define UHLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UHLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/uhlp_pkg.sv -----
// Shared types, constants and byte classification for the upgrade header list parser.
package uhlp_pkg;

  // Item carried on the input channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Item carried on the output channel
  typedef struct packed {
    logic        item_valid;
    logic [11:0] protocol_offset;
    logic [12:0] protocol_length;
    logic [11:0] version_offset;
    logic [12:0] version_length;
    logic [12:0] item_count;
    logic        value_done;
    logic        parse_error;
  } out_item_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Parse phases, one-hot
  typedef enum logic [4:0] {
    PH_SKIP  = 5'b00001,
    PH_PROTO = 5'b00010,
    PH_SLASH = 5'b00100,
    PH_VER   = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_e;

  localparam logic [7:0]  ChComma  = 8'h2C;
  localparam logic [7:0]  ChSlash  = 8'h2F;
  localparam logic [7:0]  ChSpace  = 8'h20;
  localparam logic [7:0]  ChTab    = 8'h09;
  localparam int unsigned CountW   = 13;
  localparam logic [CountW-1:0] CountMax = 13'h1FFF;

  // RFC token characters: digits, letters and the listed symbols
  function automatic logic is_token(input logic [7:0] b);
    logic r;
    unique case (b) inside
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/uhlp_in_stage.sv -----
// Input register stage: holds one accepted byte until the parser takes it.
module uhlp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uhlp_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output uhlp_pkg::stage_t  stage_o
);
  import uhlp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_valid_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign stage_o = '{valid: valid_q, item: item_q};

endmodule

// ----- hdl/uhlp_parser.sv -----
// Parser state and one-byte step: phase tracking, token offsets, count and error latch.
module uhlp_parser #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  uhlp_pkg::in_item_t item_i,
  output uhlp_pkg::out_item_t result_o
);
  import uhlp_pkg::*;

  localparam int unsigned PosW    = $clog2(MAX_LEN + 1);
  localparam int unsigned StartW  = $clog2(MAX_LEN);
  localparam int unsigned LenW    = PosW;
  localparam int unsigned OffExtW = (StartW > 12) ? StartW : 12;
  localparam int unsigned LenExtW = (LenW > 13) ? LenW : 13;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_LEN);

  phase_e              phase_q, phase_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [StartW-1:0]   pstart_q, pstart_d, vstart_q, vstart_d;
  logic [LenW-1:0]     plen_q, plen_d, vlen_q, vlen_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                err_q, err_d;
  logic                emit;
  logic [OffExtW-1:0]  pstart_ext, vstart_ext;
  logic [LenExtW-1:0]  plen_ext, vlen_ext;

  // One byte through the phase machine
  always_comb begin
    logic [7:0] b;
    logic       tok, sp, comma, bad, done;
    b        = item_i.data_byte;
    tok      = is_token(b);
    sp       = (b == ChSpace) || (b == ChTab);
    comma    = (b == ChComma);
    bad      = 1'b0;
    done     = 1'b0;
    emit     = 1'b0;
    phase_d  = phase_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    vstart_d = vstart_q;
    vlen_d   = vlen_q;
    count_d  = count_q;
    err_d    = err_q;

    if (!err_q) begin
      if (pos_q >= PosMax) begin
        err_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_SKIP: begin
            if (tok) begin
              pstart_d = StartW'(pos_q);
              plen_d   = LenW'(1);
              vstart_d = '0;
              vlen_d   = '0;
              phase_d  = PH_PROTO;
            end else if (!sp && !comma) begin
              bad = 1'b1;
            end
          end
          PH_PROTO: begin
            if (tok) plen_d = plen_q + LenW'(1);
            else if (b == ChSlash) phase_d = PH_SLASH;
            else if (sp) phase_d = PH_TRAIL;
            else if (comma) done = 1'b1;
            else bad = 1'b1;
          end
          PH_SLASH: begin
            if (tok) begin
              vstart_d = StartW'(pos_q);
              vlen_d   = LenW'(1);
              phase_d  = PH_VER;
            end else begin
              bad = 1'b1;
            end
          end
          PH_VER: begin
            if (tok) vlen_d = vlen_q + LenW'(1);
            else if (sp) phase_d = PH_TRAIL;
            else if (comma) done = 1'b1;
            else bad = 1'b1;
          end
          PH_TRAIL: begin
            if (comma) done = 1'b1;
            else if (!sp) bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
        if (bad) err_d = 1'b1;
      end
    end

    // Position saturates at the length limit
    pos_d = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;

    // End of value closes an open element; a dangling slash is an error
    if (item_i.last_byte && !err_d && !done) begin
      if (phase_d == PH_PROTO || phase_d == PH_VER || phase_d == PH_TRAIL) begin
        done = 1'b1;
      end else if (phase_d == PH_SLASH) begin
        err_d = 1'b1;
      end
    end

    // Report the element unless the count would overflow
    if (done && !err_d) begin
      phase_d = PH_SKIP;
      if (count_q >= CountMax) begin
        err_d = 1'b1;
      end else begin
        count_d = count_q + CountW'(1);
        emit    = 1'b1;
      end
    end
  end

  // State update; the last byte returns everything to reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      vstart_q <= '0;
      vlen_q   <= '0;
      count_q  <= '0;
      err_q    <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        phase_q  <= PH_SKIP;
        pos_q    <= '0;
        pstart_q <= '0;
        plen_q   <= '0;
        vstart_q <= '0;
        vlen_q   <= '0;
        count_q  <= '0;
        err_q    <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        pstart_q <= pstart_d;
        plen_q   <= plen_d;
        vstart_q <= vstart_d;
        vlen_q   <= vlen_d;
        count_q  <= count_d;
        err_q    <= err_d;
      end
    end
  end

  // Fit internal widths to the field widths
  assign pstart_ext = OffExtW'(pstart_d);
  assign vstart_ext = OffExtW'(vstart_d);
  assign plen_ext   = LenExtW'(plen_d);
  assign vlen_ext   = LenExtW'(vlen_d);

  assign result_o.item_valid      = emit;
  assign result_o.protocol_offset = emit ? pstart_ext[11:0] : 12'd0;
  assign result_o.protocol_length = emit ? plen_ext[12:0]   : 13'd0;
  assign result_o.version_offset  = emit ? vstart_ext[11:0] : 12'd0;
  assign result_o.version_length  = emit ? vlen_ext[12:0]   : 13'd0;
  assign result_o.item_count      = count_d;
  assign result_o.value_done      = item_i.last_byte;
  assign result_o.parse_error     = err_d;

endmodule

// ----- hdl/upgrade_header_list_parser.sv -----
// Top level of the HTTP Upgrade header protocol list parser.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one byte of an Upgrade
// field value per item, with last_byte set on the final byte of the value.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one item per
// input byte, in order. item_valid marks a completed protocol[/version]
// element with its offsets and lengths; item_count, parse_error and value_done
// are reported on every item. After the last byte the parser starts fresh.
// Throughput is one byte per cycle while the receiver keeps out_ready_i high:
// the phase update is a single step between the input register and the output
// register, and both registers take a new item in the cycle their current one
// moves on. An accepted byte is held in the input register, and its result is
// then written into the output register that drives out_valid_o.
// Reset clears the parse state and both stages' valid flags, dropping any items.
// When the receiver stalls, the output register holds its item, the input
// register still takes one more byte, and then in_ready_o drops until the
// output drains.
`include "upgrade_header_list_parser_defines.svh"

module upgrade_header_list_parser #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uhlp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uhlp_pkg::out_item_t out_data_o
);
  import uhlp_pkg::*;

  stage_t    stage;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      step;

  // Move the held byte when the output register is free or draining
  assign step = stage.valid && (!out_valid_q || out_ready_i);

  uhlp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .take_i    (step),
    .stage_o   (stage)
  );

  uhlp_parser #(
    .MAX_LEN(MAX_LEN)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (stage.item),
    .result_o(result)
  );

  // Output register
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `UHLP_ASSERT_IMP(a_elem_no_error, clk_i, rst_ni,
    out_valid_o && out_data_o.item_valid,
    !out_data_o.parse_error && out_data_o.item_count != 13'd0)
  `UHLP_ASSERT_IMP(a_elem_proto_len, clk_i, rst_ni,
    out_valid_o && out_data_o.item_valid, out_data_o.protocol_length != 13'd0)
  `UHLP_ASSERT_IMP(a_idle_fields_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.item_valid,
    out_data_o.protocol_length == 13'd0 && out_data_o.version_length == 13'd0)
  `UHLP_ASSERT_NXT(a_accept_fills_stage, clk_i, rst_ni,
    in_valid_i && in_ready_o, stage.valid)

endmodule

// ----- bench/upgrade_header_list_parser_checker.sv -----
// Predicts and checks every output item of the upgrade header list parser.
module upgrade_header_list_parser_checker #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  uhlp_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  uhlp_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import uhlp_pkg::*;

  // Parser state mirror
  phase_e      phase_q;
  logic [12:0] pos_q;
  logic [11:0] proto_start_q;
  logic [12:0] proto_len_q;
  logic [11:0] ver_start_q;
  logic [12:0] ver_len_q;
  logic [12:0] elements_q;
  logic        error_q;

  out_item_t   expected_items[$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void clear_parse();
    phase_q       = PH_SKIP;
    pos_q         = '0;
    proto_start_q = '0;
    proto_len_q   = '0;
    ver_start_q   = '0;
    ver_len_q     = '0;
    elements_q    = '0;
    error_q       = 1'b0;
  endfunction

  // Token bytes: digits, letters and the tchar symbols
  function automatic logic token_byte(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           b == "!" || b == "#" || b == "$" || b == "%" || b == "&" || b == 8'h27 ||
           b == "*" || b == "+" || b == "-" || b == "." || b == "^" || b == "_" ||
           b == 8'h60 || b == "|" || b == "~";
  endfunction

  // Advance the parse by one byte and return the output item it causes
  function automatic out_item_t parse_byte(input in_item_t it);
    logic      ws, comma, tok, bad, done, emit;
    out_item_t r;
    ws    = (it.data_byte == ChSpace) || (it.data_byte == ChTab);
    comma = (it.data_byte == ChComma);
    tok   = token_byte(it.data_byte);
    bad   = 1'b0;
    done  = 1'b0;
    emit  = 1'b0;

    if (!error_q) begin
      if (pos_q >= MAX_LEN) begin
        error_q = 1'b1;
      end else begin
        case (phase_q)
          PH_SKIP: begin
            if (tok) begin
              proto_start_q = pos_q[11:0];
              proto_len_q   = 13'd1;
              ver_start_q   = '0;
              ver_len_q     = '0;
              phase_q       = PH_PROTO;
            end else if (!ws && !comma) begin
              bad = 1'b1;
            end
          end
          PH_PROTO: begin
            if (tok) proto_len_q++;
            else if (it.data_byte == ChSlash) phase_q = PH_SLASH;
            else if (ws) phase_q = PH_TRAIL;
            else if (comma) done = 1'b1;
            else bad = 1'b1;
          end
          PH_SLASH: begin
            if (tok) begin
              ver_start_q = pos_q[11:0];
              ver_len_q   = 13'd1;
              phase_q     = PH_VER;
            end else begin
              bad = 1'b1;
            end
          end
          PH_VER: begin
            if (tok) ver_len_q++;
            else if (ws) phase_q = PH_TRAIL;
            else if (comma) done = 1'b1;
            else bad = 1'b1;
          end
          PH_TRAIL: begin
            if (comma) done = 1'b1;
            else if (!ws) bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
        if (bad) error_q = 1'b1;
      end
    end
    if (pos_q < MAX_LEN) pos_q++;

    // end of value closes an open element, or fails right after a slash
    if (it.last_byte && !error_q && !done) begin
      if (phase_q == PH_PROTO || phase_q == PH_VER || phase_q == PH_TRAIL) done = 1'b1;
      else if (phase_q == PH_SLASH) error_q = 1'b1;
    end

    if (done && !error_q) begin
      phase_q = PH_SKIP;
      if (elements_q >= CountMax) begin
        error_q = 1'b1;
      end else begin
        elements_q++;
        emit = 1'b1;
      end
    end

    r = '0;
    if (emit) begin
      r.item_valid      = 1'b1;
      r.protocol_offset = proto_start_q;
      r.protocol_length = proto_len_q;
      r.version_offset  = ver_start_q;
      r.version_length  = ver_len_q;
    end
    r.item_count  = elements_q;
    r.value_done  = it.last_byte;
    r.parse_error = error_q;

    if (it.last_byte) clear_parse();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [12:0] want,
                             input logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on input accept, compare on output accept
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      clear_parse();
      expected_items.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_items.push_back(parse_byte(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_items.size() == 0) begin
          $error("output item with no expected item waiting");
          mismatches++;
        end else begin
          want = expected_items.pop_front();
          check_field("item_valid", 13'(want.item_valid), 13'(out_data_i.item_valid));
          check_field("protocol_offset", 13'(want.protocol_offset),
                      13'(out_data_i.protocol_offset));
          check_field("protocol_length", want.protocol_length, out_data_i.protocol_length);
          check_field("version_offset", 13'(want.version_offset),
                      13'(out_data_i.version_offset));
          check_field("version_length", want.version_length, out_data_i.version_length);
          check_field("item_count", want.item_count, out_data_i.item_count);
          check_field("value_done", 13'(want.value_done), 13'(out_data_i.value_done));
          check_field("parse_error", 13'(want.parse_error), 13'(out_data_i.parse_error));
        end
      end
      pending_o <= expected_items.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Stimulus, flow control and verdict for the upgrade header list parser.
module testbench;
  import uhlp_pkg::*;

  localparam int unsigned ValueMax   = 4096;
  localparam int          RandomBytes = 1350;
  localparam int          CycleLimit = 4000000;
  localparam string       TokenChars =
    "!#$%&'*+-.^_|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  bit         squeeze_req = 1'b0;
  int         send_seg    = 0;
  bit         send_steady = 1'b0;
  logic [7:0] value_q[$];

  upgrade_header_list_parser #(.MAX_LEN(ValueMax)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  upgrade_header_list_parser_checker #(.MAX_LEN(ValueMax)) checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] token_char();
    int idx;
    idx = $urandom_range(0, TokenChars.len());
    // backquote is kept out of the string literal
    if (idx == TokenChars.len()) return 8'h60;
    return TokenChars[idx];
  endfunction

  // Offer one byte; returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (send_seg == 0) begin
      send_seg    = $urandom_range(10, 120);
      send_steady = ($urandom_range(0, 2) == 0);
    end
    send_seg--;
    gap = send_steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: is_last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_value();
    foreach (value_q[i]) send_byte(value_q[i], i == value_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    value_q.delete();
    for (int i = 0; i < s.len(); i++) value_q.push_back(s[i]);
    send_value();
  endtask

  // Stop offering and wait until every expected item has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_token(input int n);
    repeat (n) value_q.push_back(token_char());
  endtask

  task automatic add_ows();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      value_q.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
  endtask

  // Well-formed list with random content, sometimes damaged or replaced by noise
  task automatic make_value();
    int n_elem;
    value_q.delete();
    n_elem = $urandom_range(1, 5);
    for (int e = 0; e < n_elem; e++) begin
      add_ows();
      if ($urandom_range(0, 5) == 0) value_q.push_back(ChComma);
      add_token($urandom_range(1, 8));
      if ($urandom_range(0, 1)) begin
        value_q.push_back(ChSlash);
        add_token($urandom_range(1, 5));
      end
      add_ows();
      if (e != n_elem - 1) value_q.push_back(ChComma);
    end
    if ($urandom_range(0, 4) == 0) value_q.push_back(ChComma);
    case ($urandom_range(0, 9))
      0: value_q[$urandom_range(0, value_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        value_q.delete();
        repeat ($urandom_range(1, 6)) value_q.push_back(8'($urandom_range(0, 255)));
      end
      2: value_q.push_back(ChSlash);
      3: begin
        value_q.push_back(ChSlash);
        value_q.push_back($urandom_range(0, 1) ? ChComma : ChSpace);
      end
      default: ;
    endcase
  endtask

  // Receiver: random stalls, steady stretches, one long hold-off
  initial begin : receiver
    int stall, seg;
    bit steady, squeezed;
    stall    = 0;
    seg      = 0;
    steady   = 1'b0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (seg == 0) begin
        seg    = $urandom_range(20, 150);
        steady = ($urandom_range(0, 2) == 0);
      end
      seg--;
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 2) == 0) stall = idle_cycles();
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_bytes;
    random_bytes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: skipped separators, trailing whitespace, empty version,
    // end right after a slash, bad bytes in several phases, extreme bytes
    send_text("a/b, ,z ");
    send_text("x/");
    send_text("p/,q");
    send_text("a b");
    send_text("\tv/~");
    send_text(",");
    value_q = '{8'h00};
    send_value();
    value_q = '{"k", 8'hFF};
    send_value();

    // Full drain with the sender paused
    drain();

    // Random lists; the receiver holds off early so the parser backs up
    squeeze_req <= 1'b1;
    while (random_bytes < RandomBytes) begin
      make_value();
      random_bytes += value_q.size();
      send_value();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
